// File: rtl/kshc_pkg.sv
// Shared types, constants and digit helpers for the keypad-set countdown timer.
// Used by kshc_next and keypad_set_hms_countdown_unit; depends on nothing else.
package kshc_pkg;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_DIGIT = 3'd1;
	localparam logic [2:0] OP_RIGHT = 3'd2;
	localparam logic [2:0] OP_LEFT  = 3'd3;
	localparam logic [2:0] OP_START = 3'd4;

	localparam logic [1:0] MODE_ENTRY = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_DONE  = 2'd2;
	localparam logic [1:0] MODE_BAD   = 2'd3;

	localparam logic [6:0] SEC_MAX    = 7'd59;
	localparam logic [6:0] MIN_MAX    = 7'd59;
	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [3:0] CURSOR_END = 4'd8;
	localparam logic [3:0] DIGIT_MAX  = 4'd9;

	localparam logic [3:0] POS_HOUR_TENS  = 4'd0;
	localparam logic [3:0] POS_HOUR_UNITS = 4'd1;
	localparam logic [3:0] POS_MIN_TENS   = 4'd3;
	localparam logic [3:0] POS_MIN_UNITS  = 4'd4;
	localparam logic [3:0] POS_SEC_TENS   = 4'd6;
	localparam logic [3:0] POS_SEC_UNITS  = 4'd7;

	typedef struct packed {
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic [3:0] cursor;
		logic [1:0] mode;
	} kshc_state_t;

	// Division by ten through a reciprocal multiply, exact for any 7-bit value.
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [6:0] units_of(input logic [6:0] v);
		logic [6:0] t10;
		t10 = 7'(tens_of(v)) * 7'd10;
		return v - t10;
	endfunction

	function automatic logic [6:0] put_tens(input logic [6:0] v, input logic [3:0] d);
		logic [6:0] d10;
		d10 = 7'(d) * 7'd10;
		return d10 + units_of(v);
	endfunction

	function automatic logic [6:0] put_units(input logic [6:0] v, input logic [3:0] d);
		logic [6:0] t10;
		t10 = 7'(tens_of(v)) * 7'd10;
		return t10 + 7'(d);
	endfunction

endpackage

// File: rtl/kshc_next.sv
// Next-state logic of the countdown timer for one item: digit entry, cursor moves,
// start check and the one-second borrow countdown. Depends on kshc_pkg.
module kshc_next
	import kshc_pkg::*;
(
	input  kshc_state_t cur,
	input  logic [2:0]  opcode,
	input  logic [3:0]  digit,
	output kshc_state_t nxt
);

	kshc_state_t tick_st;
	logic        zero_now;
	logic        zero_after;
	logic        over_range;

	assign zero_now   = (cur.hours == '0) && (cur.minutes == '0) && (cur.seconds == '0);
	assign over_range = (cur.hours > HOUR_MAX) || (cur.minutes > MIN_MAX) ||
		(cur.seconds > SEC_MAX);

	always_comb begin
		tick_st = cur;
		if (cur.seconds != '0) begin
			tick_st.seconds = cur.seconds - 7'd1;
		end else if (cur.minutes != '0) begin
			tick_st.minutes = cur.minutes - 7'd1;
			tick_st.seconds = SEC_MAX;
		end else if (cur.hours != '0) begin
			tick_st.hours   = cur.hours - 7'd1;
			tick_st.minutes = MIN_MAX;
			tick_st.seconds = SEC_MAX;
		end
	end

	assign zero_after = (tick_st.hours == '0) && (tick_st.minutes == '0) &&
		(tick_st.seconds == '0);

	always_comb begin
		nxt = cur;
		if (opcode == OP_TICK) begin
			if (cur.mode == MODE_RUN) begin
				nxt = tick_st;
				if (zero_after) begin
					nxt.mode = MODE_DONE;
				end
			end
		end else if (cur.mode == MODE_ENTRY) begin
			unique case (opcode)
				OP_DIGIT: begin
					if (digit <= DIGIT_MAX) begin
						case (cur.cursor)
							POS_HOUR_TENS:  nxt.hours   = put_tens(cur.hours, digit);
							POS_HOUR_UNITS: nxt.hours   = put_units(cur.hours, digit);
							POS_MIN_TENS:   nxt.minutes = put_tens(cur.minutes, digit);
							POS_MIN_UNITS:  nxt.minutes = put_units(cur.minutes, digit);
							POS_SEC_TENS:   nxt.seconds = put_tens(cur.seconds, digit);
							POS_SEC_UNITS:  nxt.seconds = put_units(cur.seconds, digit);
							default: ;
						endcase
					end
				end
				OP_RIGHT: begin
					if (cur.cursor < CURSOR_END) begin
						nxt.cursor = cur.cursor + 4'd1;
					end
				end
				OP_LEFT: begin
					if (cur.cursor != '0) begin
						nxt.cursor = cur.cursor - 4'd1;
					end
				end
				OP_START: begin
					nxt.cursor = '0;
					if (over_range) begin
						nxt.mode = MODE_BAD;
					end else if (zero_now) begin
						nxt.mode = MODE_DONE;
					end else begin
						nxt.mode = MODE_RUN;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/keypad_set_hms_countdown_unit.sv
// Top level of the keypad-set HH:MM:SS countdown timer: input register, timer state
// and result register around kshc_next. Depends on kshc_pkg and kshc_next.
//
// The timer takes one item per clock cycle while its results are not stalled. Each item
// (a tick or a key) is held in the input register while kshc_next computes the timer
// state after it; when the result register is free, that state is loaded into both
// the timer state and the result register, which offers it to the receiver. The
// result register lets a new item in while the previous result waits; when the
// result is stalled, the input register fills and in_stall rises. Every item yields
// exactly one result holding the hours, minutes, seconds, cursor and mode after it,
// with the LED lit once the countdown has finished. Finished and invalid modes are
// left only by reset.
module keypad_set_hms_countdown_unit
	import kshc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  logic [3:0] digit,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] hours_now,
	output logic [6:0] minutes_now,
	output logic [6:0] seconds_now,
	output logic [3:0] cursor_pos,
	output logic [1:0] mode_now,
	output logic       led_on
);

	logic        vld_s1;
	logic [2:0]  opcode_s1;
	logic [3:0]  digit_s1;
	logic        out_valid_q;
	kshc_state_t state_q;
	kshc_state_t res_q;
	kshc_state_t nxt;
	logic        accept_in;
	logic        advance;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = vld_s1 && out_free;
	assign in_stall  = vld_s1 && !out_free;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept_in) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			opcode_s1 <= opcode;
			digit_s1  <= digit;
		end
	end

	kshc_next u_next (
		.cur    (state_q),
		.opcode (opcode_s1),
		.digit  (digit_s1),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.hours   <= '0;
			state_q.minutes <= '0;
			state_q.seconds <= '0;
			state_q.cursor  <= CURSOR_END;
			state_q.mode    <= MODE_ENTRY;
		end else if (advance) begin
			state_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign hours_now   = res_q.hours;
	assign minutes_now = res_q.minutes;
	assign seconds_now = res_q.seconds;
	assign cursor_pos  = res_q.cursor;
	assign mode_now    = res_q.mode;
	assign led_on      = (res_q.mode == MODE_DONE);

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cursor <= CURSOR_END)
		else $error("Cursor has left the display line.");

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == MODE_DONE || state_q.mode == MODE_BAD) |=> $stable(state_q))
		else $error("Timer state changed after halting.");

	a_cursor_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode != MODE_ENTRY) |=> $stable(state_q.cursor))
		else $error("Cursor moved outside entry mode.");

	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == MODE_RUN) |-> (state_q.hours <= HOUR_MAX &&
			state_q.minutes <= MIN_MAX && state_q.seconds <= SEC_MAX))
		else $error("Running with a time outside its range.");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_q == state_q))
		else $error("Result register differs from the timer state.");
`endif

endmodule

// File: verif/hms_timer_shadow_pkg.sv
`timescale 1ns / 1ps
// Shadow copy of the keypad-set HH:MM:SS countdown timer with the queue of the results it
// predicts, and the field by field check of each result that the block delivers.
// Depends on kshc_pkg for the opcode, mode, limit and cursor position codes.
package hms_timer_shadow_pkg;
	import kshc_pkg::*;

	typedef struct {
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic [3:0] cursor;
		logic [1:0] mode;
		logic       led;
	} timer_view_t;

	class hms_timer_shadow;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [3:0]  cursor;
		logic [1:0]  mode;
		timer_view_t due_views[$];
		int          failures;

		function new();
			hours = '0;
			minutes = '0;
			seconds = '0;
			cursor = CURSOR_END;
			mode = MODE_ENTRY;
			failures = 0;
		endfunction

		function int pending();
			return due_views.size();
		endfunction

		function logic [6:0] with_tens(logic [6:0] v, logic [3:0] d);
			int r;
			r = int'(d) * 10 + int'(v) % 10;
			return 7'(r);
		endfunction

		function logic [6:0] with_units(logic [6:0] v, logic [3:0] d);
			int r;
			r = (int'(v) / 10) * 10 + int'(d);
			return 7'(r);
		endfunction

		function void take_item(logic [2:0] op, logic [3:0] dig);
			timer_view_t v;
			if (op == OP_TICK) begin
				if (mode == MODE_RUN) begin
					if (seconds != 0) begin
						seconds = seconds - 7'd1;
					end else if (minutes != 0) begin
						minutes = minutes - 7'd1;
						seconds = SEC_MAX;
					end else if (hours != 0) begin
						hours = hours - 7'd1;
						minutes = MIN_MAX;
						seconds = SEC_MAX;
					end
					if (hours == 0 && minutes == 0 && seconds == 0)
						mode = MODE_DONE;
				end
			end else if (mode == MODE_ENTRY) begin
				case (op)
				OP_DIGIT: begin
					if (dig <= DIGIT_MAX) begin
						case (cursor)
						POS_HOUR_TENS:  hours = with_tens(hours, dig);
						POS_HOUR_UNITS: hours = with_units(hours, dig);
						POS_MIN_TENS:   minutes = with_tens(minutes, dig);
						POS_MIN_UNITS:  minutes = with_units(minutes, dig);
						POS_SEC_TENS:   seconds = with_tens(seconds, dig);
						POS_SEC_UNITS:  seconds = with_units(seconds, dig);
						default: ;
						endcase
					end
				end
				OP_RIGHT: begin
					if (cursor < CURSOR_END)
						cursor = cursor + 4'd1;
				end
				OP_LEFT: begin
					if (cursor != 0)
						cursor = cursor - 4'd1;
				end
				OP_START: begin
					cursor = '0;
					if (hours > HOUR_MAX || minutes > MIN_MAX || seconds > SEC_MAX)
						mode = MODE_BAD;
					else if (hours == 0 && minutes == 0 && seconds == 0)
						mode = MODE_DONE;
					else
						mode = MODE_RUN;
				end
				default: ;
				endcase
			end
			v = '{hours, minutes, seconds, cursor, mode, mode == MODE_DONE};
			due_views.push_back(v);
		endfunction

		function void compare_field(string what, logic [6:0] want_v, logic [6:0] got_v);
			if (want_v !== got_v) begin
				$display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
				failures++;
			end
		endfunction

		function void check_view(timer_view_t got);
			timer_view_t want;
			if (due_views.size() == 0) begin
				$display("%0t: result with none expected: %0d:%0d:%0d cursor %0d mode %0d led %0d",
					$time, got.hours, got.minutes, got.seconds, got.cursor, got.mode, got.led);
				failures++;
				return;
			end
			want = due_views.pop_front();
			compare_field("hours", want.hours, got.hours);
			compare_field("minutes", want.minutes, got.minutes);
			compare_field("seconds", want.seconds, got.seconds);
			compare_field("cursor", 7'(want.cursor), 7'(got.cursor));
			compare_field("mode", 7'(want.mode), 7'(got.mode));
			compare_field("led", 7'(want.led), 7'(got.led));
		endfunction
	endclass

endpackage

// File: verif/tb_keypad_set_hms_countdown_unit.sv
`timescale 1ns / 1ps
// Testbench for keypad_set_hms_countdown_unit: keypad entry, start and countdown items with
// random gaps and stalls. Depends on kshc_pkg, hms_timer_shadow_pkg and the timer RTL.
module tb_keypad_set_hms_countdown_unit;
	import kshc_pkg::*;
	import hms_timer_shadow_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE_CYCLES = 10;
	localparam int ENTRY_ITEMS = 700;
	localparam int ITEMS_TOTAL = 1150;
	localparam int POST_HALT_ITEMS = 40;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] opcode;
	logic [3:0] digit;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] hours_now;
	logic [6:0] minutes_now;
	logic [6:0] seconds_now;
	logic [3:0] cursor_pos;
	logic [1:0] mode_now;
	logic       led_on;

	hms_timer_shadow shadow = new;
	int items_sent = 0;
	bit calm = 1'b0;
	bit long_hold_req = 1'b0;

	keypad_set_hms_countdown_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.digit(digit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hours_now(hours_now),
		.minutes_now(minutes_now),
		.seconds_now(seconds_now),
		.cursor_pos(cursor_pos),
		.mode_now(mode_now),
		.led_on(led_on)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Timed out with %0d results outstanding.", shadow.pending());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_view('{hours_now, minutes_now, seconds_now, cursor_pos, mode_now,
				led_on});
	end

	task automatic send_key(logic [2:0] op, logic [3:0] dig);
		int gap;
		gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			opcode <= 3'($urandom);
			digit <= 4'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		digit <= dig;
		do @(posedge clk); while (in_stall);
		shadow.take_item(op, dig);
		items_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_entry_noise();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			send_key(OP_DIGIT, ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9))
				: 4'($urandom_range(10, 15)));
		else if (r < 60)
			send_key(OP_RIGHT, 4'($urandom));
		else if (r < 80)
			send_key(OP_LEFT, 4'($urandom));
		else if (r < 90)
			send_key(OP_TICK, 4'($urandom));
		else
			send_key(OP_START + 3'($urandom_range(1, 3)), 4'($urandom));
	endtask

	// Walks the cursor home and keys in all six digits of HH:MM:SS.
	task automatic set_time(int hh, int mm, int ss);
		repeat (int'(shadow.cursor) + $urandom_range(0, 1))
			send_key(OP_LEFT, 4'($urandom));
		send_key(OP_DIGIT, 4'(hh / 10));
		send_key(OP_RIGHT, 4'($urandom));
		send_key(OP_DIGIT, 4'(hh % 10));
		send_key(OP_RIGHT, 4'($urandom));
		send_key(OP_RIGHT, 4'($urandom));
		send_key(OP_DIGIT, 4'(mm / 10));
		send_key(OP_RIGHT, 4'($urandom));
		send_key(OP_DIGIT, 4'(mm % 10));
		send_key(OP_RIGHT, 4'($urandom));
		send_key(OP_RIGHT, 4'($urandom));
		send_key(OP_DIGIT, 4'(ss / 10));
		send_key(OP_RIGHT, 4'($urandom));
		send_key(OP_DIGIT, 4'(ss % 10));
	endtask

	task automatic entry_phase(int upto);
		while (items_sent < upto) begin
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 3)
				set_time($urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99));
			else
				repeat ($urandom_range(1, 8)) send_entry_noise();
		end
		calm = 1'b0;
	endtask

	initial begin
		int r;
		int hh;
		int mm;
		int ss;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_TICK;
		digit <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Spare opcodes, a tick before the start and keys at the bounds and separators.
		send_key(OP_START + 3'd3, 4'd15);
		send_key(OP_START + 3'd1, 4'd0);
		send_key(OP_START + 3'd2, 4'd9);
		send_key(OP_TICK, 4'd5);
		send_key(OP_RIGHT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_DIGIT, 4'd15);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd3);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd9);
		send_key(OP_LEFT, 4'd0);
		send_key(OP_DIGIT, 4'd0);
		wait_for_results();

		entry_phase(ENTRY_ITEMS / 2);
		// The receiver holds off while items keep coming, so the block backs up.
		calm = 1'b1;
		long_hold_req = 1'b1;
		repeat (30) send_entry_noise();
		calm = 1'b0;
		wait_for_results();
		entry_phase(ENTRY_ITEMS);

		// Only reset leaves the halted modes, so the run ends with a single countdown.
		r = $urandom_range(0, 99);
		if (r < 45) begin
			hh = 0;
			mm = $urandom_range(0, 3);
			ss = $urandom_range(0, 59);
			if (mm == 0 && ss == 0)
				ss = 1;
		end else if (r < 75) begin
			hh = 1;
			mm = 0;
			ss = $urandom_range(0, 20);
		end else if (r < 88) begin
			hh = $urandom_range(0, 23);
			mm = $urandom_range(0, 59);
			ss = $urandom_range(0, 59);
			case ($urandom_range(0, 2))
			0: hh = $urandom_range(24, 99);
			1: mm = $urandom_range(60, 99);
			default: ss = $urandom_range(60, 99);
			endcase
		end else begin
			hh = 0;
			mm = 0;
			ss = 0;
		end
		set_time(hh, mm, ss);
		send_key(OP_START, 4'($urandom));
		while (shadow.mode == MODE_RUN && items_sent < ITEMS_TOTAL - POST_HALT_ITEMS) begin
			if ($urandom_range(0, 99) < 85)
				send_key(OP_TICK, 4'($urandom));
			else
				send_key(3'($urandom_range(1, 7)), 4'($urandom));
		end
		while (items_sent < ITEMS_TOTAL)
			send_key(3'($urandom), 4'($urandom));

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.failures == 0 && shadow.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
